[sv/ssw_pkg.sv]
package ssw_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 8;
  localparam int unsigned CountW  = 16;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FROZEN_LIMIT = 1'b0,
    CFG_COOLDOWN_MS  = 1'b1
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [CountW-1:0] FrozenLimitRst = 16'd10;
  localparam logic [TimeW-1:0]  CooldownRst    = 32'd60000;

  // One input tick
  typedef struct packed {
    logic                      sensor_alive;
    logic signed [SampleW-1:0] temp_sample;
    logic [TimeW-1:0]          uptime_ms;
    logic [StatusW-1:0]        power_status;
  } tick_t;

  // One result
  typedef struct packed {
    logic               stall_event;
    logic               recovery_request;
    logic               stalled_now;
    logic [CountW-1:0]  frozen_count;
    logic [StatusW-1:0] status_echo;
    logic [TimeW-1:0]   recovery_total;
  } result_t;

  // Active configuration
  typedef struct packed {
    logic [CountW-1:0] frozen_limit;
    logic [TimeW-1:0]  cooldown_ms;
  } cfg_t;

endpackage

[sv/ssw_detect.sv]
// Stall detector: holds the watchdog state and evaluates one tick per step.
module ssw_detect (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  ssw_pkg::cfg_t    cfg,
  input  ssw_pkg::tick_t   tick,
  output ssw_pkg::result_t result
);
  import ssw_pkg::*;

  logic [SampleW-1:0] last_sample_r, last_sample_nxt;
  logic               have_sample_r, have_sample_nxt;
  logic [CountW-1:0]  repeat_count_r, repeat_count_nxt;
  logic               stall_flag_r, stall_flag_nxt;
  logic [TimeW-1:0]   last_req_time_r, last_req_time_nxt;
  logic               requested_once_r, requested_once_nxt;
  logic [TimeW-1:0]   request_total_r, request_total_nxt;

  logic               match;
  logic [CountW-1:0]  cnt_base;
  logic               stall_base;
  logic               hit;
  logic [TimeW-1:0]   elapsed;
  logic               hold;
  logic               req;

  // Repeat detection and cooldown check
  assign match      = have_sample_r && (tick.temp_sample == last_sample_r);
  assign cnt_base   = !match ? '0 :
                      (&repeat_count_r) ? repeat_count_r : repeat_count_r + 1'b1;
  assign stall_base = match && stall_flag_r;
  assign hit        = cnt_base >= cfg.frozen_limit;
  assign elapsed    = tick.uptime_ms - last_req_time_r;
  assign hold       = requested_once_r && (elapsed < cfg.cooldown_ms);
  assign req        = tick.sensor_alive && hit && !hold;

  // Next state
  always_comb begin
    last_sample_nxt    = last_sample_r;
    have_sample_nxt    = 1'b0;
    repeat_count_nxt   = '0;
    stall_flag_nxt     = 1'b0;
    last_req_time_nxt  = last_req_time_r;
    requested_once_nxt = requested_once_r;
    request_total_nxt  = request_total_r;
    if (tick.sensor_alive) begin
      last_sample_nxt  = tick.temp_sample;
      have_sample_nxt  = !req;
      repeat_count_nxt = req ? '0 : cnt_base;
      stall_flag_nxt   = hit || stall_base;
      if (req) begin
        last_req_time_nxt  = tick.uptime_ms;
        requested_once_nxt = 1'b1;
        request_total_nxt  = request_total_r + 1'b1;
      end
    end
  end

  // Result of this tick; a dead sensor reports only the total
  always_comb begin
    result.stall_event      = tick.sensor_alive && hit && !stall_base;
    result.recovery_request = req;
    result.stalled_now      = stall_flag_nxt;
    result.frozen_count     = tick.sensor_alive ? cnt_base : '0;
    result.status_echo      = result.stall_event ? tick.power_status : '0;
    result.recovery_total   = request_total_nxt;
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r    <= '0;
      have_sample_r    <= 1'b0;
      repeat_count_r   <= '0;
      stall_flag_r     <= 1'b0;
      last_req_time_r  <= '0;
      requested_once_r <= 1'b0;
      request_total_r  <= '0;
    end else if (step_en) begin
      last_sample_r    <= last_sample_nxt;
      have_sample_r    <= have_sample_nxt;
      repeat_count_r   <= repeat_count_nxt;
      stall_flag_r     <= stall_flag_nxt;
      last_req_time_r  <= last_req_time_nxt;
      requested_once_r <= requested_once_nxt;
      request_total_r  <= request_total_nxt;
    end
  end

endmodule

[sv/stuck_sensor_watchdog_core.sv]
// Channel  | Dir | Signals                       | Content
// in_      | in  | tvalid tready tdata tuser     | sensor tick
// out_     | out | tvalid tready tdata           | watchdog result
// cfg_     | in  | we addr wdata                 | register writes
//
// One tick per clock cycle sustained while out_tready stays high.
// A transaction goes from the input register to the result register;
// the watchdog state update sits between those two registers.
// Reset (rst_n low, synchronous) clears state, config to defaults, valids.
// A stalled output holds the result; the input register still takes a tick
// while it is empty, then backpressure reaches in_tready.
module stuck_sensor_watchdog_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] temp_sample, [47:16] uptime_ms, [55:48] power_status
  input  logic [ssw_pkg::InDataW-1:0]    in_tdata,
  // [0] sensor_alive
  input  logic                           in_tuser,
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] stall_event, [1] recovery_request, [2] stalled_now,
  // [18:3] frozen_count, [26:19] status_echo, [58:27] recovery_total,
  // [63:59] zero
  output logic [ssw_pkg::OutDataW-1:0]   out_tdata,
  // Configuration
  input  logic                           cfg_we,
  input  logic [ssw_pkg::CfgIdxW-1:0]    cfg_addr,
  input  logic [ssw_pkg::CfgDataW-1:0]   cfg_wdata
);
  import ssw_pkg::*;

  cfg_t    cfg_r;
  tick_t   tick_r;
  logic    tick_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frozen_limit <= FrozenLimitRst;
      cfg_r.cooldown_ms  <= CooldownRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_FROZEN_LIMIT: cfg_r.frozen_limit <= cfg_wdata[CountW-1:0];
        CFG_COOLDOWN_MS:  cfg_r.cooldown_ms  <= cfg_wdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: result register takes a held tick when empty or drained
  assign out_load  = tick_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !tick_vld_r || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_tready) begin
      tick_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r.sensor_alive <= in_tuser;
      tick_r.temp_sample  <= in_tdata[15:0];
      tick_r.uptime_ms    <= in_tdata[47:16];
      tick_r.power_status <= in_tdata[55:48];
    end
  end

  ssw_detect u_detect (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (out_load),
    .cfg     (cfg_r),
    .tick    (tick_r),
    .result  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0,
                       res_r.recovery_total,
                       res_r.status_echo,
                       res_r.frozen_count,
                       res_r.stalled_now,
                       res_r.recovery_request,
                       res_r.stall_event};

endmodule
